### design/bbd_pkg.sv
package bbd_pkg;

  localparam int unsigned MaxWidthDef   = 4096;
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned CfgBits       = 13;
  localparam int unsigned RowBits       = 13;
  localparam int unsigned MaxHeight     = 4096;
  localparam int unsigned WidthResetDef = 640;
  localparam int unsigned HeightReset   = 480;

  typedef enum logic {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } cfg_index_e;

  typedef enum logic {
    OpSample = 1'b0,
    OpDrain  = 1'b1
  } op_e;

  // Position of the window center and the border mirrors that apply to it.
  typedef struct packed {
    logic emit;
    logic last;
    logic lmir;
    logic rmir;
    logic tmir;
    logic bmir;
    logic xodd;
    logic yodd;
  } pos_t;

endpackage

### design/bbd_line_ram.sv
module bbd_line_ram #(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned DATA_BITS = 12,
  localparam int unsigned AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bbd_ctrl.sv
module bbd_ctrl import bbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned AW         = $clog2(MAX_WIDTH),
  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1),
  localparam int unsigned NW         = $clog2(MAX_WIDTH + 2)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgBits-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   op_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   advance_i,
  output logic                   accept_o,
  output logic [AW-1:0]          addr_a_o,
  output logic [SAMPLE_BITS-1:0] fresh_a_o,
  output logic                   b_valid_o,
  output logic [AW-1:0]          addr_b_o,
  output logic [SAMPLE_BITS-1:0] fresh_b_o,
  output pos_t                   pos_b_o
);

  localparam int unsigned WidthReset = (WidthResetDef > MAX_WIDTH) ? MAX_WIDTH : WidthResetDef;

  logic [WW-1:0]          width_q;
  logic [CfgBits-1:0]     height_q;
  logic [WW-1:0]          width_clamp;
  logic [CfgBits-1:0]     height_clamp;
  logic [AW-1:0]          col_q;
  logic [RowBits-1:0]     row_q;
  logic [NW-1:0]          seen_q;
  logic                   b_valid_q;
  logic [AW-1:0]          addr_b_q;
  logic [SAMPLE_BITS-1:0] fresh_b_q;
  pos_t                   pos_b_q;
  logic                   accept;
  logic                   primed;
  logic                   col_zero;
  logic                   row_wrap;
  logic [RowBits-1:0]     y;
  logic [SAMPLE_BITS-1:0] fresh;
  pos_t                   pos;

  always_comb begin
    if (cfg_data_i < CfgBits'(2)) begin
      width_clamp = WW'(2);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      width_clamp = WW'(MAX_WIDTH);
    end else begin
      width_clamp = WW'(cfg_data_i);
    end
    if (cfg_data_i < CfgBits'(2)) begin
      height_clamp = CfgBits'(2);
    end else if (32'(cfg_data_i) > MaxHeight) begin
      height_clamp = CfgBits'(MaxHeight);
    end else begin
      height_clamp = cfg_data_i;
    end
  end

  assign accept   = in_valid_i & advance_i;
  assign fresh    = (op_i == OpDrain) ? '0 : sample_i;
  assign primed   = (seen_q == NW'(width_q) + NW'(1));
  assign col_zero = (col_q == '0);
  assign row_wrap = (WW'(col_q) + WW'(1) >= width_q);
  assign y        = col_zero ? row_q - RowBits'(2) : row_q - RowBits'(1);

  // The center lags the newest sample by one row and one column.
  always_comb begin
    pos.emit = primed;
    pos.lmir = (col_q == AW'(1));
    pos.rmir = col_zero;
    pos.tmir = (y == '0);
    pos.bmir = (y == height_q - CfgBits'(1));
    pos.xodd = col_zero ? ~width_q[0] : ~col_q[0];
    pos.yodd = y[0];
    pos.last = pos.rmir & pos.bmir;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WW'(WidthReset);
      height_q  <= CfgBits'(HeightReset);
      col_q     <= '0;
      row_q     <= '0;
      seen_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgWidth:  width_q  <= width_clamp;
          CfgHeight: height_q <= height_clamp;
          default:   ;
        endcase
        col_q  <= '0;
        row_q  <= '0;
        seen_q <= '0;
      end else if (accept) begin
        if (primed && pos.last) begin
          col_q  <= '0;
          row_q  <= '0;
          seen_q <= '0;
        end else begin
          if (row_wrap) begin
            col_q <= '0;
            row_q <= row_q + RowBits'(1);
          end else begin
            col_q <= col_q + AW'(1);
          end
          if (!primed) begin
            seen_q <= seen_q + NW'(1);
          end
        end
      end
      if (advance_i) begin
        b_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_b_q  <= col_q;
      fresh_b_q <= fresh;
      pos_b_q   <= pos;
    end
  end

  assign accept_o  = accept;
  assign addr_a_o  = col_q;
  assign fresh_a_o = fresh;
  assign b_valid_o = b_valid_q;
  assign addr_b_o  = addr_b_q;
  assign fresh_b_o = fresh_b_q;
  assign pos_b_o   = pos_b_q;

endmodule

### design/bbd_window.sv
module bbd_window import bbd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   b_valid_i,
  input  pos_t                   pos_i,
  input  logic [SAMPLE_BITS-1:0] up_i,
  input  logic [SAMPLE_BITS-1:0] mid_i,
  input  logic [SAMPLE_BITS-1:0] fresh_i,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] red_o,
  output logic [SAMPLE_BITS-1:0] green_o,
  output logic [SAMPLE_BITS-1:0] blue_o,
  output logic                   last_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SW = SAMPLE_BITS + 2;

  logic [SB-1:0] win_q [3][3];
  logic [SB-1:0] win_d [3][3];
  logic [1:0]    cl, cr, rt, rb;
  logic [SB-1:0] pc, pl, pr, pu, pd, pul, pur, pdl, pdr;
  logic [SW-1:0] diag_sum, cross_sum;
  logic [SB:0]   horz_sum, vert_sum;
  logic [SB-1:0] diag, cross_avg, horz, vert;
  logic [SB-1:0] red_d, green_d, blue_d;
  logic          out_valid_q;
  logic [SB-1:0] red_q, green_q, blue_q;
  logic          last_q;
  logic          step;

  assign step = advance_i & b_valid_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = up_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = fresh_i;
  end

  // A neighbor beyond the frame border is replaced by the one opposite it.
  assign cl = pos_i.lmir ? 2'd2 : 2'd0;
  assign cr = pos_i.rmir ? 2'd0 : 2'd2;
  assign rt = pos_i.tmir ? 2'd2 : 2'd0;
  assign rb = pos_i.bmir ? 2'd0 : 2'd2;

  always_comb begin
    pc  = win_d[1][1];
    pl  = win_d[1][cl];
    pr  = win_d[1][cr];
    pu  = win_d[rt][1];
    pd  = win_d[rb][1];
    pul = win_d[rt][cl];
    pur = win_d[rt][cr];
    pdl = win_d[rb][cl];
    pdr = win_d[rb][cr];
    diag_sum  = SW'(pul) + SW'(pur) + SW'(pdl) + SW'(pdr);
    cross_sum = SW'(pl) + SW'(pu) + SW'(pr) + SW'(pd);
    horz_sum  = (SB + 1)'(pl) + (SB + 1)'(pr);
    vert_sum  = (SB + 1)'(pu) + (SB + 1)'(pd);
    diag      = diag_sum[SW-1:2];
    cross_avg = cross_sum[SW-1:2];
    horz      = horz_sum[SB:1];
    vert      = vert_sum[SB:1];
    if (pos_i.yodd) begin
      if (pos_i.xodd) begin
        red_d = diag;  green_d = cross_avg; blue_d = pc;
      end else begin
        red_d = vert;  green_d = pc;    blue_d = horz;
      end
    end else begin
      if (pos_i.xodd) begin
        red_d = horz;  green_d = pc;    blue_d = vert;
      end else begin
        red_d = pc;    green_d = cross_avg; blue_d = diag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      out_valid_q <= b_valid_i & pos_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      win_q <= win_d;
    end
    if (step && pos_i.emit) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      last_q  <= pos_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign last_o      = last_q;

endmodule

### design/bilinear_bayer_demosaic.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  op_i, sample_i
// out      output     out_valid_o / out_stall_i red_o, green_o, blue_o, last_in_frame_o
// cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One request is taken per cycle while in_stall_o is low; a pixel is valid on the output
// once the request completing its window has passed through the line memory read,
// made at the accepting edge, and the output register that this read feeds.
// The whole pipeline holds while a pixel waits under out_stall_i.
// Reset clears counters and valid flags at once; the line memories need no clearing pass.
module bilinear_bayer_demosaic import bbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgBits-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] red_o,
  output logic [SAMPLE_BITS-1:0] green_o,
  output logic [SAMPLE_BITS-1:0] blue_o,
  output logic                   last_in_frame_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic                   advance;
  logic                   accept;
  logic [AW-1:0]          addr_a;
  logic [AW-1:0]          addr_b;
  logic [SAMPLE_BITS-1:0] fresh_a;
  logic [SAMPLE_BITS-1:0] fresh_b;
  logic                   b_valid;
  pos_t                   pos_b;
  logic [SAMPLE_BITS-1:0] mid_rd;
  logic [SAMPLE_BITS-1:0] up_rd;

  assign advance    = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~advance;

  bbd_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .advance_i   (advance),
    .accept_o    (accept),
    .addr_a_o    (addr_a),
    .fresh_a_o   (fresh_a),
    .b_valid_o   (b_valid),
    .addr_b_o    (addr_b),
    .fresh_b_o   (fresh_b),
    .pos_b_o     (pos_b)
  );

  // Consecutive requests address different columns except right after a frame
  // restart; the stale upper line value read there only reaches window rows
  // that are shifted out before the first pixel of the new frame.
  bbd_line_ram #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (SAMPLE_BITS)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (addr_a),
    .wdata_i (fresh_a),
    .re_i    (accept),
    .raddr_i (addr_a),
    .rdata_o (mid_rd)
  );

  bbd_line_ram #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (SAMPLE_BITS)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid & advance),
    .waddr_i (addr_b),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (addr_a),
    .rdata_o (up_rd)
  );

  bbd_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .b_valid_i   (b_valid),
    .pos_i       (pos_b),
    .up_i        (up_rd),
    .mid_i       (mid_rd),
    .fresh_i     (fresh_b),
    .out_valid_o (out_valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_in_frame_o)
  );

endmodule

### design/bbd_checker.sv
module bbd_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] red_o,
  input logic [SAMPLE_BITS-1:0] green_o,
  input logic [SAMPLE_BITS-1:0] blue_o,
  input logic                   last_in_frame_o
);

  property p_stall_only_when_blocked;
    @(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (out_valid_o && out_stall_i);
  endproperty

  property p_pixel_follows_request;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2);
  endproperty

  property p_out_valid_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=> out_valid_o;
  endproperty

  property p_out_payload_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=>
        ($stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(last_in_frame_o));
  endproperty

  a_stall_only_when_blocked: assert property (p_stall_only_when_blocked)
    else $error("input stalled while the output is free");
  a_pixel_follows_request: assert property (p_pixel_follows_request)
    else $error("pixel appeared without a request two cycles earlier");
  a_out_valid_holds: assert property (p_out_valid_holds)
    else $error("output valid dropped while stalled");
  a_out_payload_holds: assert property (p_out_payload_holds)
    else $error("output payload changed while stalled");

endmodule

bind bilinear_bayer_demosaic bbd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
